FILE: sv/servo_packet_framer_deframer_core_assert.svh
// assertion macros for the servo packet framer and deframer core
// no dependencies; taken in by the top level only
`ifndef SERVO_PACKET_FRAMER_DEFRAMER_CORE_ASSERT_SVH
`define SERVO_PACKET_FRAMER_DEFRAMER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define SPFD_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("assertion failed");
`define SPFD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SPFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SPFD_ASSERT_NEVER(label, clk, rst_n, cond)
`define SPFD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define SPFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/spfd_pkg.sv
// shared types and constants of the servo packet framer and deframer
// no dependencies
package spfd_pkg;

    localparam logic [7:0] MAGIC_BYTE    = 8'hFF;
    localparam logic [7:0] MAX_PARAMS    = 8'd250;
    localparam logic [7:0] LEN_EXTRA     = 8'd2;
    localparam logic [7:0] MAX_LEN       = MAX_PARAMS + LEN_EXTRA;
    localparam logic [7:0] TIMEOUT_RESET = 8'd10;
    localparam logic [7:0] TICK_MAX      = 8'hFF;

    localparam logic [8:0] RX_POS_ID     = 9'd2;
    localparam logic [8:0] RX_POS_LEN    = 9'd3;
    localparam logic [8:0] RX_POS_ERR    = 9'd4;
    localparam logic [8:0] RX_POS_PARAM  = 9'd5;
    localparam logic [8:0] RX_OVERHEAD   = 9'd4;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [2:0] BEAT_MAGIC0 = 3'd0;
    localparam logic [2:0] BEAT_MAGIC1 = 3'd1;
    localparam logic [2:0] BEAT_ID     = 3'd2;
    localparam logic [2:0] BEAT_LEN    = 3'd3;
    localparam logic [2:0] BEAT_CMD    = 3'd4;
    localparam logic [2:0] BEAT_CSUM   = 3'd5;
    localparam logic [2:0] BEAT_PARAM  = 3'd0;
    localparam logic [2:0] BEAT_PCSUM  = 3'd1;

    typedef enum logic [2:0] {
        KIND_TX_START = 3'd0,
        KIND_TX_PARAM = 3'd1,
        KIND_RX_BYTE  = 3'd2,
        KIND_TICK     = 3'd3,
        KIND_ARM      = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        OUT_TX_BYTE  = 2'd0,
        OUT_RX_PARAM = 2'd1,
        OUT_RX_DONE  = 2'd2
    } t_out_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CSUM_ERR = 2'd1,
        ST_TIMEOUT  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        JOB_TX_START = 2'd0,
        JOB_TX_PARAM = 2'd1,
        JOB_RX_PARAM = 2'd2,
        JOB_RX_DONE  = 2'd3
    } t_job_kind;

    typedef struct packed {
        t_job_kind  kind;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic       with_csum;
        t_status    status;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        t_out_kind  out_kind;
        logic [7:0] tx_byte;
        logic       tx_last;
        logic [7:0] rx_param;
        logic [7:0] rx_param_index;
        logic [7:0] rx_device;
        logic [7:0] rx_status_error;
        logic [7:0] rx_count;
        t_status    result_status;
    } t_result;

endpackage

FILE: sv/spfd_in_if.sv
// input item channel of the servo packet framer and deframer
// no dependencies
interface spfd_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] servo_id;
    logic [7:0] command;
    logic [7:0] param_count;
    logic [7:0] data_byte;

    modport source (output valid, kind, servo_id, command, param_count, data_byte,
                    input ready);
    modport sink   (input valid, kind, servo_id, command, param_count, data_byte,
                    output ready);
endinterface

FILE: sv/spfd_out_if.sv
// result item channel of the servo packet framer and deframer
// no dependencies
interface spfd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic [7:0] rx_param;
    logic [7:0] rx_param_index;
    logic [7:0] rx_device;
    logic [7:0] rx_status_error;
    logic [7:0] rx_count;
    logic [1:0] result_status;

    modport source (output valid, out_kind, tx_byte, tx_last, rx_param, rx_param_index,
                           rx_device, rx_status_error, rx_count, result_status,
                    input ready);
    modport sink   (input valid, out_kind, tx_byte, tx_last, rx_param, rx_param_index,
                          rx_device, rx_status_error, rx_count, result_status,
                    output ready);
endinterface

FILE: sv/spfd_cfg_if.sv
// configuration write channel carrying the timeout register value
// no dependencies
interface spfd_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: sv/servo_packet_framer_deframer_core.sv
// top level of the servo bus packet framer and deframer
// depends on spfd_pkg, the channel interfaces, spfd_front, spfd_queue, spfd_back
//
//  channel  dir  carries
//  i_in     in   kind, servo_id, command, param_count, data_byte
//  o_out    out  one result transaction per cycle from the output register while o_out is ready
//  i_cfg    in   timeout_ticks write data, ready whenever out of reset
//
// an input transaction is taken each cycle while the four-entry job queue has room
// results leave at one per cycle while the output is not stalled: a start gives five or six, a parameter one or two,
// a received byte or tick at most one; the back part's beat counter sets this
// reset is synchronous active low and clears all state but the queue storage and output data, timeout_ticks goes to 10
// a stalled output holds its register; input stalls only once the queue is full
module servo_packet_framer_deframer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spfd_in_if.sink    i_in,
    spfd_cfg_if.sink   i_cfg,
    spfd_out_if.source o_out
);

    `include "servo_packet_framer_deframer_core_assert.svh"

    logic              push;
    logic              pop;
    spfd_pkg::t_job    push_job;
    spfd_pkg::t_job    head_job;
    spfd_pkg::t_q_stat q_stat;

    spfd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_job    (push_job)
    );

    spfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    spfd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (head_job),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_out    (o_out)
    );

    `SPFD_ASSERT_NEVER(a_no_push_full, i_clk, i_rst_n, push && q_stat.full)
    `SPFD_ASSERT_NEVER(a_no_pop_empty, i_clk, i_rst_n, pop && q_stat.empty)
    `SPFD_ASSERT_IMPLIES(a_last_is_tx, i_clk, i_rst_n, o_out.valid && o_out.tx_last, o_out.out_kind == spfd_pkg::OUT_TX_BYTE)

endmodule

FILE: sv/spfd_front.sv
// front part: accepts items, keeps framer and deframer state, queues jobs
// depends on spfd_pkg, spfd_in_if, spfd_cfg_if
module spfd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    spfd_in_if.sink          i_in,
    spfd_cfg_if.sink         i_cfg,
    input  spfd_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output spfd_pkg::t_job   o_job
);

    logic [7:0] r_timeout_ticks;
    logic [7:0] r_tx_sum,        n_tx_sum;
    logic [7:0] r_tx_remaining,  n_tx_remaining;
    logic [8:0] r_rx_position,   n_rx_position;
    logic [7:0] r_rx_length,     n_rx_length;
    logic [7:0] r_rx_sum,        n_rx_sum;
    logic [7:0] r_rx_id_held,    n_rx_id_held;
    logic [7:0] r_rx_error_held, n_rx_error_held;
    logic       r_rx_armed,      n_rx_armed;
    logic [7:0] r_tick_count,    n_tick_count;

    logic       accept;
    logic       need_job;
    logic [7:0] cnt_sat;
    logic [7:0] tx_len;
    logic [7:0] tx_sum_start;
    logic [7:0] tx_sum_param;
    logic [7:0] tx_rem_param;
    logic [7:0] len_eff;
    logic [7:0] sum_eff;
    logic [7:0] id_eff;
    logic [7:0] err_eff;
    logic [8:0] pos1;
    logic [8:0] total;
    logic       len_ok;
    logic [7:0] tick_next;

    assign i_cfg.ready = i_rst_n;
    assign i_in.ready  = i_rst_n && !i_q_stat.full;
    assign accept      = i_in.valid && i_in.ready;
    assign o_push      = accept && need_job;

    assign cnt_sat      = (i_in.param_count > spfd_pkg::MAX_PARAMS) ?
                          spfd_pkg::MAX_PARAMS : i_in.param_count;
    assign tx_len       = cnt_sat + spfd_pkg::LEN_EXTRA;
    assign tx_sum_start = i_in.servo_id + tx_len + i_in.command;
    assign tx_sum_param = r_tx_sum + i_in.data_byte;
    assign tx_rem_param = r_tx_remaining - 8'd1;

    assign len_eff = (r_rx_position == spfd_pkg::RX_POS_LEN) ? i_in.data_byte : r_rx_length;
    assign id_eff  = (r_rx_position == spfd_pkg::RX_POS_ID)  ? i_in.data_byte : r_rx_id_held;
    assign err_eff = (r_rx_position == spfd_pkg::RX_POS_ERR) ? i_in.data_byte : r_rx_error_held;
    assign sum_eff = (r_rx_position == spfd_pkg::RX_POS_ID ||
                      r_rx_position == spfd_pkg::RX_POS_LEN ||
                      r_rx_position == spfd_pkg::RX_POS_ERR) ?
                     r_rx_sum + i_in.data_byte : r_rx_sum;
    assign pos1    = r_rx_position + 9'd1;
    assign total   = {1'b0, len_eff} + spfd_pkg::RX_OVERHEAD;
    assign len_ok  = (len_eff >= spfd_pkg::LEN_EXTRA) && (len_eff <= spfd_pkg::MAX_LEN);
    assign tick_next = (r_tick_count < spfd_pkg::TICK_MAX) ? r_tick_count + 8'd1
                                                           : r_tick_count;

    always_comb begin
        n_tx_sum        = r_tx_sum;
        n_tx_remaining  = r_tx_remaining;
        n_rx_position   = r_rx_position;
        n_rx_length     = r_rx_length;
        n_rx_sum        = r_rx_sum;
        n_rx_id_held    = r_rx_id_held;
        n_rx_error_held = r_rx_error_held;
        n_rx_armed      = r_rx_armed;
        n_tick_count    = r_tick_count;
        need_job        = 1'b0;
        o_job           = '0;
        case (spfd_pkg::t_kind'(i_in.kind))
            spfd_pkg::KIND_TX_START: begin
                need_job        = 1'b1;
                o_job.kind      = spfd_pkg::JOB_TX_START;
                o_job.b0        = i_in.servo_id;
                o_job.b1        = tx_len;
                o_job.b2        = i_in.command;
                o_job.b3        = ~tx_sum_start;
                o_job.with_csum = (cnt_sat == 8'd0);
                n_tx_sum        = tx_sum_start;
                n_tx_remaining  = cnt_sat;
            end
            spfd_pkg::KIND_TX_PARAM: begin
                if (r_tx_remaining != 8'd0) begin
                    need_job        = 1'b1;
                    o_job.kind      = spfd_pkg::JOB_TX_PARAM;
                    o_job.b0        = i_in.data_byte;
                    o_job.b3        = ~tx_sum_param;
                    o_job.with_csum = (tx_rem_param == 8'd0);
                    n_tx_sum        = tx_sum_param;
                    n_tx_remaining  = tx_rem_param;
                end
            end
            spfd_pkg::KIND_RX_BYTE: begin
                if (r_rx_armed) begin
                    n_rx_length     = len_eff;
                    n_rx_id_held    = id_eff;
                    n_rx_error_held = err_eff;
                    n_rx_sum        = sum_eff;
                    if (r_rx_position < spfd_pkg::RX_POS_LEN) begin
                        n_rx_position = pos1;
                    end else if (!len_ok) begin
                        if (pos1 >= total) begin
                            need_job     = 1'b1;
                            o_job.kind   = spfd_pkg::JOB_RX_DONE;
                            o_job.b0     = id_eff;
                            o_job.b1     = err_eff;
                            o_job.status = spfd_pkg::ST_CSUM_ERR;
                            n_rx_armed   = 1'b0;
                        end else begin
                            n_rx_position = pos1;
                        end
                    end else if (r_rx_position >= spfd_pkg::RX_POS_PARAM && pos1 < total) begin
                        need_job      = 1'b1;
                        o_job.kind    = spfd_pkg::JOB_RX_PARAM;
                        o_job.b0      = i_in.data_byte;
                        o_job.b1      = 8'(r_rx_position - spfd_pkg::RX_POS_PARAM);
                        n_rx_sum      = sum_eff + i_in.data_byte;
                        n_rx_position = pos1;
                    end else if (pos1 == total) begin
                        need_job     = 1'b1;
                        o_job.kind   = spfd_pkg::JOB_RX_DONE;
                        o_job.b0     = id_eff;
                        o_job.b1     = err_eff;
                        o_job.b2     = len_eff - spfd_pkg::LEN_EXTRA;
                        o_job.status = (~sum_eff == i_in.data_byte) ? spfd_pkg::ST_OK
                                                                    : spfd_pkg::ST_CSUM_ERR;
                        n_rx_armed   = 1'b0;
                    end else begin
                        n_rx_position = pos1;
                    end
                end
            end
            spfd_pkg::KIND_TICK: begin
                if (r_rx_armed) begin
                    n_tick_count = tick_next;
                    if (tick_next >= r_timeout_ticks) begin
                        need_job     = 1'b1;
                        o_job.kind   = spfd_pkg::JOB_RX_DONE;
                        o_job.status = spfd_pkg::ST_TIMEOUT;
                        n_rx_armed   = 1'b0;
                    end
                end
            end
            spfd_pkg::KIND_ARM: begin
                n_rx_armed      = 1'b1;
                n_rx_position   = '0;
                n_rx_length     = '0;
                n_rx_sum        = '0;
                n_rx_id_held    = '0;
                n_rx_error_held = '0;
                n_tick_count    = '0;
            end
            default: begin
                need_job = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ticks <= spfd_pkg::TIMEOUT_RESET;
            r_tx_sum        <= '0;
            r_tx_remaining  <= '0;
            r_rx_position   <= '0;
            r_rx_length     <= '0;
            r_rx_sum        <= '0;
            r_rx_id_held    <= '0;
            r_rx_error_held <= '0;
            r_rx_armed      <= 1'b0;
            r_tick_count    <= '0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_timeout_ticks <= i_cfg.data;
            end
            if (accept) begin
                r_tx_sum        <= n_tx_sum;
                r_tx_remaining  <= n_tx_remaining;
                r_rx_position   <= n_rx_position;
                r_rx_length     <= n_rx_length;
                r_rx_sum        <= n_rx_sum;
                r_rx_id_held    <= n_rx_id_held;
                r_rx_error_held <= n_rx_error_held;
                r_rx_armed      <= n_rx_armed;
                r_tick_count    <= n_tick_count;
            end
        end
    end

endmodule

FILE: sv/spfd_queue.sv
// short job queue between the front and back parts
// depends on spfd_pkg
module spfd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  spfd_pkg::t_job    i_job,
    input  logic              i_pop,
    output spfd_pkg::t_job    o_job,
    output spfd_pkg::t_q_stat o_stat
);

    spfd_pkg::t_job            r_mem [spfd_pkg::Q_DEPTH];
    logic [spfd_pkg::Q_AW-1:0] r_wr_ptr;
    logic [spfd_pkg::Q_AW-1:0] r_rd_ptr;
    logic [spfd_pkg::Q_AW:0]   r_count;

    assign o_job        = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == (spfd_pkg::Q_AW+1)'(spfd_pkg::Q_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: sv/spfd_back.sv
// back part: expands queued jobs into result transactions, one per cycle while the output is not stalled
// depends on spfd_pkg, spfd_out_if
module spfd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spfd_pkg::t_job    i_job,
    input  spfd_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    spfd_out_if.source        o_out
);

    logic                r_out_valid;
    spfd_pkg::t_result   r_res;
    spfd_pkg::t_result   beat_res;
    logic [2:0]          r_beat;
    logic                last_beat;
    logic                load;

    assign load  = !i_q_stat.empty && (!r_out_valid || o_out.ready);
    assign o_pop = load && last_beat;

    always_comb begin
        beat_res  = '0;
        last_beat = 1'b1;
        case (i_job.kind)
            spfd_pkg::JOB_TX_START: begin
                beat_res.out_kind = spfd_pkg::OUT_TX_BYTE;
                last_beat = i_job.with_csum ? (r_beat == spfd_pkg::BEAT_CSUM)
                                            : (r_beat == spfd_pkg::BEAT_CMD);
                case (r_beat)
                    spfd_pkg::BEAT_MAGIC0, spfd_pkg::BEAT_MAGIC1:
                        beat_res.tx_byte = spfd_pkg::MAGIC_BYTE;
                    spfd_pkg::BEAT_ID:  beat_res.tx_byte = i_job.b0;
                    spfd_pkg::BEAT_LEN: beat_res.tx_byte = i_job.b1;
                    spfd_pkg::BEAT_CMD: beat_res.tx_byte = i_job.b2;
                    default: begin
                        beat_res.tx_byte = i_job.b3;
                        beat_res.tx_last = 1'b1;
                    end
                endcase
            end
            spfd_pkg::JOB_TX_PARAM: begin
                beat_res.out_kind = spfd_pkg::OUT_TX_BYTE;
                if (r_beat == spfd_pkg::BEAT_PARAM) begin
                    beat_res.tx_byte = i_job.b0;
                    last_beat        = !i_job.with_csum;
                end else begin
                    beat_res.tx_byte = i_job.b3;
                    beat_res.tx_last = 1'b1;
                    last_beat        = (r_beat == spfd_pkg::BEAT_PCSUM);
                end
            end
            spfd_pkg::JOB_RX_PARAM: begin
                beat_res.out_kind       = spfd_pkg::OUT_RX_PARAM;
                beat_res.rx_param       = i_job.b0;
                beat_res.rx_param_index = i_job.b1;
            end
            spfd_pkg::JOB_RX_DONE: begin
                beat_res.out_kind        = spfd_pkg::OUT_RX_DONE;
                beat_res.rx_device       = i_job.b0;
                beat_res.rx_status_error = i_job.b1;
                beat_res.rx_count        = i_job.b2;
                beat_res.result_status   = i_job.status;
            end
            default: begin
                last_beat = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= beat_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_beat      <= '0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_beat      <= last_beat ? 3'd0 : r_beat + 3'd1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.out_kind        = r_res.out_kind;
    assign o_out.tx_byte         = r_res.tx_byte;
    assign o_out.tx_last         = r_res.tx_last;
    assign o_out.rx_param        = r_res.rx_param;
    assign o_out.rx_param_index  = r_res.rx_param_index;
    assign o_out.rx_device       = r_res.rx_device;
    assign o_out.rx_status_error = r_res.rx_status_error;
    assign o_out.rx_count        = r_res.rx_count;
    assign o_out.result_status   = r_res.result_status;

endmodule

FILE: bench/spfd_result_checker.sv
`timescale 1ns / 100ps
// result checker for the servo packet framer and deframer core
// watches the input, configuration and result channels, predicts every result and
// compares; depends on spfd_pkg and the three channel interfaces
module spfd_result_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    spfd_in_if   in_mon,
    spfd_cfg_if  cfg_mon,
    spfd_out_if  out_mon,
    output int   o_errors,
    output int   o_pending
);
    import spfd_pkg::*;

    logic [7:0] timeout_ticks;
    logic [7:0] tx_sum;
    logic [7:0] tx_left;
    logic [8:0] rx_pos;
    logic [7:0] rx_len;
    logic [7:0] rx_sum;
    logic [7:0] rx_id;
    logic [7:0] rx_err;
    logic       rx_armed;
    logic [7:0] ticks;

    t_result results_due[$];

    function automatic void push_tx(input logic [7:0] b, input logic last);
        t_result r;
        r = '0;
        r.out_kind = OUT_TX_BYTE;
        r.tx_byte = b;
        r.tx_last = last;
        results_due.push_back(r);
    endfunction

    function automatic void push_param(input logic [7:0] b, input logic [7:0] idx);
        t_result r;
        r = '0;
        r.out_kind = OUT_RX_PARAM;
        r.rx_param = b;
        r.rx_param_index = idx;
        results_due.push_back(r);
    endfunction

    function automatic void push_done(input logic [7:0] dev, input logic [7:0] err,
                                      input logic [7:0] cnt, input t_status st);
        t_result r;
        r = '0;
        r.out_kind = OUT_RX_DONE;
        r.rx_device = dev;
        r.rx_status_error = err;
        r.rx_count = cnt;
        r.result_status = st;
        results_due.push_back(r);
    endfunction

    task automatic predict_link_output(input logic [2:0] kind, input logic [7:0] id,
                                       input logic [7:0] cmd, input logic [7:0] cnt_in,
                                       input logic [7:0] b);
        logic [7:0] cnt;
        logic [7:0] len;
        logic [8:0] pos;
        logic [8:0] total;
        t_status    st;
        case (kind)
            KIND_TX_START: begin
                cnt = (cnt_in > MAX_PARAMS) ? MAX_PARAMS : cnt_in;
                len = cnt + LEN_EXTRA;
                push_tx(MAGIC_BYTE, 1'b0);
                push_tx(MAGIC_BYTE, 1'b0);
                push_tx(id, 1'b0);
                push_tx(len, 1'b0);
                push_tx(cmd, 1'b0);
                tx_sum = id + len + cmd;
                tx_left = cnt;
                if (cnt == 8'd0) begin
                    push_tx(~tx_sum, 1'b1);
                end
            end
            KIND_TX_PARAM: begin
                if (tx_left != 8'd0) begin
                    push_tx(b, 1'b0);
                    tx_sum = tx_sum + b;
                    tx_left = tx_left - 8'd1;
                    if (tx_left == 8'd0) begin
                        push_tx(~tx_sum, 1'b1);
                    end
                end
            end
            KIND_RX_BYTE: begin
                if (rx_armed) begin
                    pos = rx_pos;
                    if (pos == RX_POS_ID) begin
                        rx_id = b;
                        rx_sum = rx_sum + b;
                    end else if (pos == RX_POS_LEN) begin
                        rx_len = b;
                        rx_sum = rx_sum + b;
                    end else if (pos == RX_POS_ERR) begin
                        rx_err = b;
                        rx_sum = rx_sum + b;
                    end
                    if (pos < RX_POS_LEN) begin
                        rx_pos = pos + 9'd1;
                    end else begin
                        total = {1'b0, rx_len} + RX_OVERHEAD;
                        if (rx_len < LEN_EXTRA || rx_len > MAX_LEN) begin
                            if (pos + 9'd1 >= total) begin
                                push_done(rx_id, rx_err, 8'd0, ST_CSUM_ERR);
                                rx_armed = 1'b0;
                            end else begin
                                rx_pos = pos + 9'd1;
                            end
                        end else if (pos >= RX_POS_PARAM && pos + 9'd1 < total) begin
                            rx_sum = rx_sum + b;
                            push_param(b, 8'(pos - RX_POS_PARAM));
                            rx_pos = pos + 9'd1;
                        end else if (pos + 9'd1 == total) begin
                            st = (~rx_sum == b) ? ST_OK : ST_CSUM_ERR;
                            push_done(rx_id, rx_err, rx_len - LEN_EXTRA, st);
                            rx_armed = 1'b0;
                        end else begin
                            rx_pos = pos + 9'd1;
                        end
                    end
                end
            end
            KIND_TICK: begin
                if (rx_armed) begin
                    if (ticks < TICK_MAX) begin
                        ticks = ticks + 8'd1;
                    end
                    if (ticks >= timeout_ticks) begin
                        push_done(8'd0, 8'd0, 8'd0, ST_TIMEOUT);
                        rx_armed = 1'b0;
                    end
                end
            end
            KIND_ARM: begin
                rx_armed = 1'b1;
                rx_pos = '0;
                rx_len = '0;
                rx_sum = '0;
                rx_id = '0;
                rx_err = '0;
                ticks = '0;
            end
            default: begin
            end
        endcase
    endtask

    function automatic string show(input t_result r);
        return $sformatf("kind %0d tx %h last %0d param %h idx %0d dev %h err %h cnt %0d st %0d",
                         r.out_kind, r.tx_byte, r.tx_last, r.rx_param, r.rx_param_index,
                         r.rx_device, r.rx_status_error, r.rx_count, r.result_status);
    endfunction

    task automatic check_result();
        t_result got;
        t_result want;
        got.out_kind = t_out_kind'(out_mon.out_kind);
        got.tx_byte = out_mon.tx_byte;
        got.tx_last = out_mon.tx_last;
        got.rx_param = out_mon.rx_param;
        got.rx_param_index = out_mon.rx_param_index;
        got.rx_device = out_mon.rx_device;
        got.rx_status_error = out_mon.rx_status_error;
        got.rx_count = out_mon.rx_count;
        got.result_status = t_status'(out_mon.result_status);
        if (results_due.size() == 0) begin
            o_errors++;
            if (o_errors <= 10) begin
                $display("%0t: unexpected result transaction: %s", $realtime, show(got));
            end
        end else begin
            want = results_due.pop_front();
            if (got.out_kind !== want.out_kind || got.tx_byte !== want.tx_byte
                    || got.tx_last !== want.tx_last || got.rx_param !== want.rx_param
                    || got.rx_param_index !== want.rx_param_index
                    || got.rx_device !== want.rx_device
                    || got.rx_status_error !== want.rx_status_error
                    || got.rx_count !== want.rx_count
                    || got.result_status !== want.result_status) begin
                o_errors++;
                if (o_errors <= 10) begin
                    $display("%0t: mismatch\n  expected %s\n  actual   %s", $realtime,
                             show(want), show(got));
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            timeout_ticks = TIMEOUT_RESET;
            tx_sum = '0;
            tx_left = '0;
            rx_pos = '0;
            rx_len = '0;
            rx_sum = '0;
            rx_id = '0;
            rx_err = '0;
            rx_armed = 1'b0;
            ticks = '0;
            results_due.delete();
            o_errors = 0;
        end else begin
            if (cfg_mon.valid && cfg_mon.ready) begin
                timeout_ticks = cfg_mon.data;
            end
            if (in_mon.valid && in_mon.ready) begin
                predict_link_output(in_mon.kind, in_mon.servo_id, in_mon.command,
                                    in_mon.param_count, in_mon.data_byte);
            end
            if (out_mon.valid && out_mon.ready) begin
                check_result();
            end
        end
        o_pending = results_due.size();
    end
endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// top of the bench for servo_packet_framer_deframer_core: clock, reset and stimulus
// depends on spfd_pkg, the channel interfaces, the core and spfd_result_checker
module testbench;
    import spfd_pkg::*;

    localparam logic [2:0] KIND_SPARE = 3'd7;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE = 40;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   cycles = 0;
    int   send_gap = 14;
    int   recv_gap = 49;
    int   items_sent = 0;
    int   items_noise = 0;
    logic [7:0] timeout_now = TIMEOUT_RESET;

    spfd_in_if  in_ch ();
    spfd_cfg_if cfg_ch ();
    spfd_out_if out_ch ();

    servo_packet_framer_deframer_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    spfd_result_checker i_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_mon    (in_ch),
        .cfg_mon   (cfg_ch),
        .out_mon   (out_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready = ($urandom_range(99) >= recv_gap);
        end
    end

    task automatic put_item(input logic [2:0] kind, input logic [7:0] id,
                            input logic [7:0] cmd, input logic [7:0] cnt,
                            input logic [7:0] b);
        while ($urandom_range(99) < send_gap) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.kind = kind;
        in_ch.servo_id = id;
        in_ch.command = cmd;
        in_ch.param_count = cnt;
        in_ch.data_byte = b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic put_kind(input logic [2:0] kind, input logic [7:0] b);
        put_item(kind, 8'($urandom), 8'($urandom), 8'($urandom), b);
    endtask

    task automatic write_timeout(input logic [7:0] value);
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.data = value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
        timeout_now = value;
    endtask

    task automatic run_to_timeout();
        repeat ((timeout_now > 8'd30) ? 0 : timeout_now + 1) put_kind(KIND_TICK, 8'($urandom));
    endtask

    task automatic tx_packet();
        int cnt;
        int sends;
        cnt = ($urandom_range(19) == 0) ? $urandom_range(255, 240) : $urandom_range(6);
        put_item(KIND_TX_START, 8'($urandom), 8'($urandom), 8'(cnt), 8'($urandom));
        sends = (cnt > 6) ? $urandom_range(4) : cnt;
        if ($urandom_range(9) == 0) begin
            sends = $urandom_range(sends);
        end
        repeat (sends) begin
            if ($urandom_range(19) == 0) begin
                put_kind(KIND_RX_BYTE, 8'($urandom));
            end
            put_kind(KIND_TX_PARAM, 8'($urandom));
        end
    endtask

    task automatic rx_packet();
        int         pick;
        int         len;
        int         total;
        int         upto;
        int         pos;
        bit         good;
        logic [7:0] sum;
        logic [7:0] b;
        logic [7:0] id;
        logic [7:0] err;
        pick = $urandom_range(19);
        if (pick == 0) len = $urandom_range(1);
        else if (pick == 1) len = $urandom_range(255, 253);
        else if (pick == 2) len = int'(MAX_LEN);
        else len = $urandom_range(9, 2);
        total = len + 4;
        upto = (len > 20) ? $urandom_range(12, 6) : total;
        if ($urandom_range(9) == 0) begin
            upto = $urandom_range(total - 1);
        end
        good = ($urandom_range(3) != 0);
        id = 8'($urandom);
        err = ($urandom_range(3) == 0) ? 8'($urandom) : 8'h00;
        sum = '0;
        put_kind(KIND_ARM, 8'($urandom));
        for (pos = 0; pos < upto; pos++) begin
            if (pos < 2) b = ($urandom_range(3) == 0) ? 8'($urandom) : MAGIC_BYTE;
            else if (pos == 2) b = id;
            else if (pos == 3) b = len[7:0];
            else if (pos == 4) b = err;
            else if (pos == total - 1) b = good ? ~sum : 8'($urandom);
            else b = 8'($urandom);
            if (pos >= 2 && pos < total - 1) begin
                sum = sum + b;
            end
            if ($urandom_range(14) == 0) begin
                put_kind(KIND_TICK, 8'($urandom));
            end
            if ($urandom_range(29) == 0) begin
                put_kind(KIND_TX_PARAM, 8'($urandom));
            end
            put_kind(KIND_RX_BYTE, b);
        end
        if (upto < total) begin
            run_to_timeout();
        end else if ($urandom_range(3) == 0) begin
            put_kind(KIND_RX_BYTE, 8'($urandom));
        end
    endtask

    task automatic noise();
        repeat (5) begin
            put_kind(3'($urandom_range(7)), 8'($urandom));
            items_noise++;
        end
    endtask

    task automatic random_phase(input int n_items);
        int stop;
        int sel;
        stop = items_sent - items_noise + n_items;
        while (items_sent - items_noise < stop) begin
            sel = $urandom_range(99);
            if (sel < 30) begin
                tx_packet();
            end else if (sel < 65) begin
                rx_packet();
            end else if (sel < 77) begin
                put_kind(KIND_ARM, 8'($urandom));
                run_to_timeout();
            end else begin
                noise();
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.kind = KIND_TICK;
        in_ch.servo_id = '0;
        in_ch.command = '0;
        in_ch.param_count = '0;
        in_ch.data_byte = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // zero-count packet, extreme fields, stray parameter
        put_item(KIND_TX_START, 8'h00, 8'h00, 8'h00, 8'h00);
        put_item(KIND_TX_START, 8'hFF, 8'hFF, 8'd2, 8'hFF);
        put_item(KIND_TX_PARAM, 8'h00, 8'h00, 8'h00, 8'h00);
        put_item(KIND_TX_PARAM, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        put_item(KIND_TX_PARAM, 8'h00, 8'h00, 8'h00, 8'h5A);
        // saturated count, then abandoned by a fresh start
        put_item(KIND_TX_START, 8'h01, 8'h02, 8'hFF, 8'h00);
        put_item(KIND_TX_PARAM, 8'h00, 8'h00, 8'h00, 8'hAA);
        put_item(KIND_TX_START, 8'h05, 8'h03, 8'd1, 8'h00);
        put_item(KIND_TX_PARAM, 8'h00, 8'h00, 8'h00, 8'h7F);
        // receive side idle, spare kind
        put_item(KIND_RX_BYTE, 8'h00, 8'h00, 8'h00, 8'h33);
        put_item(KIND_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
        put_item(KIND_SPARE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        // well-formed status packet
        put_kind(KIND_ARM, 8'h00);
        put_kind(KIND_RX_BYTE, MAGIC_BYTE);
        put_kind(KIND_RX_BYTE, MAGIC_BYTE);
        put_kind(KIND_RX_BYTE, 8'h01);
        put_kind(KIND_RX_BYTE, 8'h04);
        put_kind(KIND_RX_BYTE, 8'h00);
        put_kind(KIND_RX_BYTE, 8'h12);
        put_kind(KIND_RX_BYTE, 8'h34);
        put_kind(KIND_RX_BYTE, 8'hB4);
        // zero length ends at the length byte
        put_kind(KIND_ARM, 8'h00);
        put_kind(KIND_RX_BYTE, MAGIC_BYTE);
        put_kind(KIND_RX_BYTE, MAGIC_BYTE);
        put_kind(KIND_RX_BYTE, 8'h02);
        put_kind(KIND_RX_BYTE, 8'h00);

        random_phase(40);
        write_timeout(8'd1);
        send_gap = 49;
        recv_gap = 14;
        random_phase(40);
        write_timeout(8'd255);
        random_phase(30);
        write_timeout(8'd0);
        send_gap = 0;
        recv_gap = 0;
        random_phase(30);
        write_timeout(8'($urandom_range(40, 2)));
        random_phase(35);

        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule

FILE: files.f
+incdir+sv
sv/spfd_pkg.sv
sv/spfd_in_if.sv
sv/spfd_out_if.sv
sv/spfd_cfg_if.sv
sv/spfd_front.sv
sv/spfd_queue.sv
sv/spfd_back.sv
sv/servo_packet_framer_deframer_core.sv
bench/spfd_result_checker.sv
bench/testbench.sv
